FILE: hdl/labb_pkg.sv
`default_nettype none
package labb_pkg;

	localparam int LINE_BYTES = 32;
	localparam int CNT_W      = $clog2(LINE_BYTES + 1);

	localparam logic [7:0] DELIM_RST = 8'h0A;

	// register indexes on the config port
	localparam logic REG_DELIM = 1'b0;

	// result kinds
	localparam logic KIND_LINE     = 1'b0;
	localparam logic KIND_OVERFLOW = 1'b1;

	typedef logic [7:0]       data_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_LAST
	} state_t;

endpackage
`default_nettype wire

FILE: hdl/labb_cell.sv
`default_nettype none
module labb_cell import labb_pkg::*; (
	input  wire        clk,
	input  wire cell_ctrl_t ctrl,
	input  wire data_t load_data,
	input  wire data_t nxt_data,
	output data_t      data
);

	data_t data_q;

	// shift toward the head on drain, else take a new byte when addressed
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= nxt_data;
		end else if (ctrl.load) begin
			data_q <= load_data;
		end
	end

	assign data = data_q;

endmodule
`default_nettype wire

FILE: hdl/line_assembling_byte_buffer_core.sv
// an ordinary byte is written into the row when accepted; an overflow word is valid in the cycle after accept
// a delimiter on an empty store gives its word in the cycle after accept; otherwise the row drains
// one word a cycle while the output register is free, fill + 1 words, input held off meanwhile
// throughput otherwise 1 byte per cycle while the output register is free
// the drain rate is set by the single head cell of the shifting row feeding the output register
// reset clears the fill count, the state and the output valid; delimiter resets to line feed
`default_nettype none
module line_assembling_byte_buffer_core import labb_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	// stream in
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] data_byte
	// stream out
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // [7:0] line_byte
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast,
	// config
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t state_q, state_d;
	cnt_t   fill_q, fill_d;
	data_t  delim_q;
	data_t  held_q;

	logic   m_tvalid_q;
	data_t  m_data_q;
	logic   m_kind_q;
	logic   m_last_q;

	logic   out_free;
	logic   out_load;
	data_t  out_byte;
	logic   out_kind;
	logic   out_last;
	logic   append;
	logic   drain_shift;
	logic   hold_load;
	logic   is_delim;

	data_t      cell_data [LINE_BYTES];
	cell_ctrl_t cell_ctrl [LINE_BYTES];

	// config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DELIM)) begin
			delim_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = 32'h0;
		if (paddr[2] == REG_DELIM) begin
			prdata = {24'h0, delim_q};
		end
	end

	// row of cells, cell 0 holds the oldest byte
	for (genvar i = 0; i < LINE_BYTES; i++) begin : g_cell
		data_t nxt;
		if (i == LINE_BYTES - 1) begin : g_tail
			assign nxt = 8'h00;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end

		assign cell_ctrl[i].shift = drain_shift;
		assign cell_ctrl[i].load  = append && (fill_q == CNT_W'(i));

		labb_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl[i]),
			.load_data (s_tdata),
			.nxt_data  (nxt),
			.data      (cell_data[i])
		);
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign is_delim = (s_tdata == delim_q);

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		s_tready    = 1'b0;
		out_load    = 1'b0;
		out_byte    = s_tdata;
		out_kind    = KIND_LINE;
		out_last    = 1'b0;
		append      = 1'b0;
		drain_shift = 1'b0;
		hold_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = out_free;
				if (s_tvalid && out_free) begin
					if (is_delim) begin
						if (fill_q == '0) begin
							out_load = 1'b1;
							out_last = 1'b1;
						end else begin
							hold_load = 1'b1;
							state_d   = ST_DRAIN;
						end
					end else if (fill_q == CNT_W'(LINE_BYTES)) begin
						out_load = 1'b1;
						out_kind = KIND_OVERFLOW;
					end else begin
						append = 1'b1;
						fill_d = fill_q + cnt_t'(1);
					end
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					out_load    = 1'b1;
					out_byte    = cell_data[0];
					drain_shift = 1'b1;
					fill_d      = fill_q - cnt_t'(1);
					if (fill_q == CNT_W'(1)) begin
						state_d = ST_LAST;
					end
				end
			end
			ST_LAST: begin
				if (out_free) begin
					out_load = 1'b1;
					out_byte = held_q;
					out_last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hold_load) begin
			held_q <= s_tdata;
		end
		if (out_load) begin
			m_data_q <= out_byte;
			m_kind_q <= out_kind;
			m_last_q <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

endmodule
`default_nettype wire
